// ===== rtl/mkd_pkg.sv =====
package mkd_pkg;

    localparam int unsigned SYM_W  = 8;
    localparam int unsigned DIG_W  = 4;
    localparam int unsigned POS_W  = 3;
    localparam int unsigned NSLOT  = 3;
    localparam int unsigned CNT_W  = 2;

    localparam logic [SYM_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [SYM_W-1:0] CH_NINE  = 8'h39;
    localparam logic [SYM_W-1:0] CH_HASH  = 8'h23;
    localparam logic [SYM_W-1:0] CH_SPACE = 8'h20;
    localparam logic [SYM_W-1:0] CH_NUL   = 8'h00;

    typedef struct packed {
        logic             run_active;
        logic [DIG_W-1:0] run_digit;
        logic [POS_W-1:0] tap_position;
        logic             more_than_once;
    } run_state_t;

    typedef struct packed {
        logic [SYM_W-1:0] text_char;
        logic             string_end;
    } result_t;

    typedef struct packed {
        run_state_t       state;
        result_t [NSLOT-1:0] res;
        logic [CNT_W-1:0] count;
    } decode_t;

    // letters per key
    function automatic logic [POS_W-1:0] group_len(input logic [DIG_W-1:0] d);
        logic [POS_W-1:0] n;
        case (d)
            4'd0:    n = 3'd2;
            4'd1:    n = 3'd6;
            4'd7:    n = 3'd5;
            4'd9:    n = 3'd5;
            default: n = 3'd4;
        endcase
        return n;
    endfunction

    function automatic logic [SYM_W-1:0] group_char(input logic [DIG_W-1:0] d,
                                                     input logic [POS_W-1:0] p);
        logic [SYM_W-1:0] c;
        c = CH_NUL;
        case (d)
            4'd1: begin
                case (p)
                    3'd0:    c = ".";
                    3'd1:    c = ",";
                    3'd2:    c = "?";
                    3'd3:    c = "!";
                    3'd4:    c = "-";
                    default: c = "1";
                endcase
            end
            4'd2: c = (p == 3'd3) ? "2" : 8'("a" + p);
            4'd3: c = (p == 3'd3) ? "3" : 8'("d" + p);
            4'd4: c = (p == 3'd3) ? "4" : 8'("g" + p);
            4'd5: c = (p == 3'd3) ? "5" : 8'("j" + p);
            4'd6: c = (p == 3'd3) ? "6" : 8'("m" + p);
            4'd7: c = (p == 3'd4) ? "7" : 8'("p" + p);
            4'd8: c = (p == 3'd3) ? "8" : 8'("t" + p);
            4'd9: c = (p == 3'd4) ? "9" : 8'("w" + p);
            default: c = CH_NUL;
        endcase
        return c;
    endfunction

    // character released when a pending run closes
    function automatic logic [SYM_W-1:0] flush_char(input run_state_t s);
        logic [POS_W-1:0] p;
        logic [SYM_W-1:0] c;
        p = (s.tap_position >= group_len(s.run_digit)) ? '0 : s.tap_position;
        if (s.run_digit == '0) begin
            c = s.more_than_once ? CH_ZERO : CH_SPACE;
        end else begin
            c = group_char(s.run_digit, p);
        end
        return c;
    endfunction

endpackage

// ===== rtl/multitap_keypad_decoder.sv =====
// multitap keypad decoder
// input stream: one ascii keypad symbol per request on s_tdata, s_tlast marks
// the last symbol of a string. output stream: decoded characters on m_tdata,
// m_tlast set on the zero terminator that closes each string.
// runs of one digit key collapse to a single letter, released when the run
// ends; '#' gives a space, other non-digits only end the run.
// each accepted symbol yields zero to three characters. they are decoded into
// a holding stage at the accepting edge, then leave one per cycle while the
// output is not stalled, through the output register to m_tdata.
// throughput is one symbol per cycle while each symbol yields at most one
// character and m_tready stays high; after a symbol yielding more characters,
// s_tready stays low until at most one of them is left queued.
// reset clears the pending run, empties the holding stage and invalidates the output register.
// when m_tready is low the output register holds its character, the holding
// stage fills, and s_tready drops until space frees up; nothing is lost.
module multitap_keypad_decoder
    import mkd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] symbol
    input  logic       s_tlast,   // final_symbol
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] text_char
    output logic       m_tlast    // string_end
);

    run_state_t          state_reg, state_next;
    result_t [NSLOT-1:0] hold_reg, hold_next;
    logic [CNT_W-1:0]    hold_cnt_reg, hold_cnt_next;
    logic                out_valid_reg, out_valid_next;
    result_t             out_reg, out_next;

    decode_t dec;
    logic    accept;
    logic    out_free;
    logic    move;

    mkd_decode u_decode (
        .state        (state_reg),
        .symbol       (s_tdata),
        .final_symbol (s_tlast),
        .dec          (dec)
    );

    always_comb begin
        out_free = !out_valid_reg || m_tready;
        move     = out_free && (hold_cnt_reg != '0);
        s_tready = (hold_cnt_reg == '0) || ((hold_cnt_reg == 2'd1) && out_free);
        accept   = s_tvalid && s_tready;

        state_next    = accept ? dec.state : state_reg;
        hold_next     = hold_reg;
        hold_cnt_next = hold_cnt_reg;
        if (accept) begin
            hold_next     = dec.res;
            hold_cnt_next = dec.count;
        end else if (move) begin
            // shift the queue down by one
            hold_next[0]  = hold_reg[1];
            hold_next[1]  = hold_reg[2];
            hold_cnt_next = hold_cnt_reg - 1'b1;
        end

        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (move) begin
            out_valid_next = 1'b1;
            out_next       = hold_reg[0];
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= '0;
            hold_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            hold_cnt_reg  <= hold_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_reg <= hold_next;
        out_reg  <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.text_char;
    assign m_tlast  = out_reg.string_end;

`ifndef SYNTHESIS
    // the terminator always carries a zero character
    a_term_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata == 8'h00))
        else $error("terminator with nonzero character");

    // no new request while two or more characters are still queued
    a_no_accept_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (hold_cnt_reg >= 2'd2) |-> !s_tready)
        else $error("request taken with queue full");

    // a pending run always holds a real digit
    a_digit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.run_active |-> (state_reg.run_digit <= 4'd9))
        else $error("pending run with bad digit");

    // a final symbol leaves no run pending
    a_final_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !state_reg.run_active)
        else $error("run left pending after final symbol");
`endif

endmodule

// ===== rtl/mkd_decode.sv =====
module mkd_decode
    import mkd_pkg::*;
(
    input  run_state_t       state,
    input  logic [SYM_W-1:0] symbol,
    input  logic             final_symbol,
    output decode_t          dec
);

    logic             is_digit;
    logic [DIG_W-1:0] digit;
    logic             same_run;
    logic             flush_a;
    logic             flush_b;
    logic [POS_W:0]   pos_inc;
    run_state_t       mid;
    run_state_t       nxt;
    result_t [3:0]    slot;
    logic [3:0]       slot_v;
    logic [CNT_W-1:0] k;

    always_comb begin
        is_digit = (symbol >= CH_ZERO) && (symbol <= CH_NINE);
        digit    = DIG_W'(symbol - CH_ZERO);
        same_run = state.run_active && is_digit && (digit == state.run_digit);
        flush_a  = state.run_active && !same_run && (state.run_digit <= 4'd9);

        mid = state;
        if (!same_run) begin
            mid.run_active = 1'b0;
        end
        if (is_digit) begin
            if (same_run) begin
                pos_inc = {1'b0, state.tap_position} + 1'b1;
                mid.tap_position = (pos_inc >= {1'b0, group_len(digit)}) ?
                                   '0 : pos_inc[POS_W-1:0];
                mid.more_than_once = 1'b1;
            end else begin
                pos_inc = '0;
                mid.run_active     = 1'b1;
                mid.run_digit      = digit;
                mid.tap_position   = '0;
                mid.more_than_once = 1'b0;
            end
        end else begin
            pos_inc = '0;
        end

        nxt     = mid;
        flush_b = final_symbol && mid.run_active && (mid.run_digit <= 4'd9);
        if (final_symbol) begin
            nxt.run_active = 1'b0;
        end

        // results in emission order: old run, hash space, last run, terminator
        slot[0] = '{text_char: flush_char(state), string_end: 1'b0};
        slot[1] = '{text_char: CH_SPACE, string_end: 1'b0};
        slot[2] = '{text_char: flush_char(mid), string_end: 1'b0};
        slot[3] = '{text_char: CH_NUL, string_end: 1'b1};
        slot_v  = {final_symbol, flush_b, (symbol == CH_HASH), flush_a};

        dec.state = nxt;
        dec.res   = '0;
        k         = '0;
        for (int i = 0; i < 4; i++) begin
            if (slot_v[i]) begin
                dec.res[k] = slot[i];
                k = k + 1'b1;
            end
        end
        dec.count = k;
    end

endmodule
